>>> src/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time iteration block.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// widths of the point components, the configuration data and the register index, and the radius fraction bits
	localparam int C_W         = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int RADIUS_FRAC = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_RADIUS = 1'd1;

	// reset values of the configuration registers
	localparam logic [CFG_DATA_W-1:0] MAX_ITER_RST = 32'd1000;
	localparam logic [CFG_DATA_W-1:0] RADIUS_RST   = 32'd67108864;

	// exact products are scaled down and saturated at this magnitude
	localparam logic [62:0] PROD_SAT = 63'd1 << 61;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic mult;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic escape;
		logic at_cap;
	} sts_t;

endpackage

>>> src/mbe_datapath.sv
// ----------------------------------------------------------------------------
// mbe_datapath
// Complex square-and-add datapath: product registers, z registers, step
// counter, escape compare, configuration registers and result registers.
// ----------------------------------------------------------------------------
module mbe_datapath import mbe_pkg::*; #(
	parameter int FRAC_BITS = 28,
	parameter int ITER_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [C_W-1:0]       c_real,
	input  logic signed [C_W-1:0]       c_imag,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	output logic                        in_set,
	output logic [ITER_BITS-1:0]        iterations
);

	localparam int MAG_W  = FRAC_BITS + 5;
	localparam int CW     = FRAC_BITS + 6;
	localparam int PW     = 2 * MAG_W;
	localparam int SC_W   = PW - FRAC_BITS;
	localparam int QW     = (SC_W < 62) ? SC_W : 62;
	localparam int SUM_W  = ((QW + 1 > 31) ? QW + 1 : 31) + 2;
	localparam int LIM_SH = 2 * FRAC_BITS - RADIUS_FRAC;
	localparam int ESC_W  = PW + 1;

	localparam logic signed [SUM_W-1:0] COMP_LIM = SUM_W'(1) << (FRAC_BITS + 4);
	localparam logic signed [CW-1:0]    COMP_LIM_C = CW'(1) << (FRAC_BITS + 4);

	logic [ITER_BITS-1:0]    max_iter_q;
	logic [CFG_DATA_W-1:0]   radius_q;
	logic signed [C_W-1:0]   c_r_q;
	logic signed [C_W-1:0]   c_i_q;
	logic signed [CW-1:0]    zr_q;
	logic signed [CW-1:0]    zi_q;
	logic [ITER_BITS-1:0]    n_q;
	logic [PW-1:0]           sr_q;
	logic [PW-1:0]           si_q;
	logic [PW-1:0]           sx_q;
	logic                    res_in_set_q;
	logic [ITER_BITS-1:0]    res_iter_q;

	logic [CW-1:0]           zr_neg;
	logic [CW-1:0]           zi_neg;
	logic [MAG_W-1:0]        ar;
	logic [MAG_W-1:0]        ai;
	logic [QW-1:0]           qr;
	logic [QW-1:0]           qi;
	logic [QW-1:0]           qx;
	logic signed [SUM_W-1:0] qx_s;
	logic signed [SUM_W-1:0] nr;
	logic signed [SUM_W-1:0] ni;
	logic [ESC_W-1:0]        mag_sum;
	logic [ESC_W-1:0]        limit;

	// product shifted down by the fraction bits, truncated, saturated
	function automatic logic [QW-1:0] scale_prod(input logic [PW-1:0] p);
		logic [SC_W-1:0] sc;
		sc = p[PW-1:FRAC_BITS];
		if (sc > PROD_SAT) begin
			return QW'(PROD_SAT);
		end
		return QW'(sc);
	endfunction

	function automatic logic signed [CW-1:0] clamp_comp(input logic signed [SUM_W-1:0] v);
		if (v > COMP_LIM) begin
			return COMP_LIM_C;
		end else if (v < -COMP_LIM) begin
			return -COMP_LIM_C;
		end
		return v[CW-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	// magnitudes of z, at most 2^(FRAC_BITS+4) after the clamp
	assign zr_neg = -zr_q;
	assign zi_neg = -zi_q;
	assign ar     = zr_q[CW-1] ? zr_neg[MAG_W-1:0] : zr_q[MAG_W-1:0];
	assign ai     = zi_q[CW-1] ? zi_neg[MAG_W-1:0] : zi_q[MAG_W-1:0];

	assign qr = scale_prod(sr_q);
	assign qi = scale_prod(si_q);
	assign qx = scale_prod(sx_q);

	always_comb begin
		qx_s = $signed({{(SUM_W - QW){1'b0}}, qx});
		if (zr_q[CW-1] != zi_q[CW-1]) begin
			qx_s = -qx_s;
		end
		nr = $signed({{(SUM_W - QW){1'b0}}, qr}) - $signed({{(SUM_W - QW){1'b0}}, qi})
			+ $signed({{(SUM_W - C_W){c_r_q[C_W-1]}}, c_r_q});
		ni = (qx_s <<< 1) + $signed({{(SUM_W - C_W){c_i_q[C_W-1]}}, c_i_q});
	end

	// exact |z|^2 against the radius aligned to 2*FRAC_BITS fraction bits
	assign mag_sum    = {1'b0, sr_q} + {1'b0, si_q};
	assign limit      = ESC_W'(radius_q) << LIM_SH;
	assign sts.escape = mag_sum > limit;
	assign sts.at_cap = n_q >= max_iter_q;

	assign in_set     = res_in_set_q;
	assign iterations = res_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST[ITER_BITS-1:0];
			radius_q   <= RADIUS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_ITER:   max_iter_q <= cfg_data[ITER_BITS-1:0];
				REG_ESC_RADIUS: radius_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_r_q <= c_real;
			c_i_q <= c_imag;
			zr_q  <= '0;
			zi_q  <= '0;
			n_q   <= '0;
		end else if (cmd.step) begin
			zr_q <= clamp_comp(nr);
			zi_q <= clamp_comp(ni);
			n_q  <= n_q + 1'b1;
		end
		if (cmd.mult) begin
			sr_q <= ar * ar;
			si_q <= ai * ai;
			sx_q <= ar * ai;
		end
		if (cmd.finish) begin
			res_in_set_q <= !sts.escape;
			res_iter_q   <= n_q;
		end
	end

endmodule

>>> src/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: takes a point, alternates multiply and test/update cycles, and
// holds the output valid until the result transaction completes.
// ----------------------------------------------------------------------------
module mbe_ctrl import mbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_TEST
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   done;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		done       = (state_q == ST_TEST) && (sts.escape || sts.at_cap);
		slot_free  = !out_valid_q || out_ready;
		cmd.load   = in_valid && (state_q == ST_IDLE);
		cmd.mult   = (state_q == ST_MUL);
		cmd.step   = (state_q == ST_TEST) && !sts.escape && !sts.at_cap;
		cmd.finish = done && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					// wait here while the previous result is still unclaimed
					if (cmd.step) begin
						state_q <= ST_MUL;
					end else if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/mandelbrot_escape_test.sv
// one point is worked on at a time; each step is a multiply state followed by a
// test/update state around the shared three-product multiplier bank; the result
// sits in an output register so the next point can be taken
// reset: arst_n clears control state; max_iterations returns to 1000 and
// escape_radius_sq to 4.0
// ----------------------------------------------------------------------------
// mandelbrot_escape_test
// Fixed-point escape-time test of one complex point per transaction.
// ----------------------------------------------------------------------------
module mandelbrot_escape_test import mbe_pkg::*; #(
	parameter int FRAC_BITS = 28,
	parameter int ITER_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [C_W-1:0] c_real,
	input  logic signed [C_W-1:0] c_imag,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  in_set,
	output logic [ITER_BITS-1:0]  iterations
);

	cmd_t cmd;
	sts_t sts;

	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbe_datapath #(
		.FRAC_BITS (FRAC_BITS),
		.ITER_BITS (ITER_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.c_real     (c_real),
		.c_imag     (c_imag),
		.cmd        (cmd),
		.sts        (sts),
		.in_set     (in_set),
		.iterations (iterations)
	);

endmodule

>>> src/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker #(
	parameter int ITER_BITS = 12
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 in_set,
	input logic [ITER_BITS-1:0] iterations,
	input logic                 cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(in_set) && $stable(iterations))
		else $error("result changed while stalled");

	// one point at a time: input closes right after a transaction
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after transaction");

	// no result can appear in the cycle after a point is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// finishing a point reopens the input together with the result
	a_finish_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && cfg_ready)
		else $error("input not reopened on finish");

endmodule

bind mandelbrot_escape_test mbe_checker #(
	.ITER_BITS (ITER_BITS)
) u_mbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.in_set     (in_set),
	.iterations (iterations),
	.cfg_ready  (cfg_ready)
);

>>> test/mandelbrot_escape_test_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_tb
// Drives complex points into the escape-time block under random flow control
// and checks each verdict against a fixed-point predictor kept in the bench.
// Covers field extremes, the radius boundary, cap and radius register limits
// and three random passes with different idling on each side.
// ----------------------------------------------------------------------------
module mandelbrot_escape_test_tb;
	import mbe_pkg::*;

	localparam int FRAC   = 28;
	localparam int ITER_W = 12;
	localparam longint COMP_LIM = 64'sd1 << (FRAC + 4);
	localparam logic [63:0] SAT_MAG = 64'd1 << 61;

	typedef struct {
		logic [C_W-1:0]    cr;
		logic [C_W-1:0]    ci;
		logic              in_set;
		logic [ITER_W-1:0] iterations;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [C_W-1:0] c_real = '0;
	logic signed [C_W-1:0] c_imag = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  in_set;
	logic [ITER_W-1:0]     iterations;

	// bench copy of the configuration registers
	logic [ITER_W-1:0]     cap_model = MAX_ITER_RST[ITER_W-1:0];
	logic [CFG_DATA_W-1:0] radius_model = RADIUS_RST;

	verdict_t pending_verdicts[$];
	verdict_t head;
	int failures = 0;
	int send_idle_pct = 10;
	int sink_stall_pct = 46;

	mandelbrot_escape_test #(
		.FRAC_BITS(FRAC),
		.ITER_BITS(ITER_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.c_real(c_real),
		.c_imag(c_imag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.in_set(in_set),
		.iterations(iterations)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// exact product brought down to FRAC fraction bits, truncated and saturated
	function automatic longint scale_product(input logic [127:0] p);
		logic [127:0] v;
		v = p >> FRAC;
		return (v > 128'(SAT_MAG)) ? longint'(SAT_MAG) : longint'(v[63:0]);
	endfunction

	function automatic longint clamp_component(input longint v);
		if (v > COMP_LIM) return COMP_LIM;
		if (v < -COMP_LIM) return -COMP_LIM;
		return v;
	endfunction

	function automatic verdict_t escape_time(input logic signed [C_W-1:0] cr,
			input logic signed [C_W-1:0] ci);
		longint zr, zi, qr, qi, qx, nr, ni;
		logic [127:0] ar, ai, sr, si, bound;
		int n;
		bit done;
		verdict_t v;
		zr = 0;
		zi = 0;
		n = 0;
		done = 1'b0;
		v.cr = cr;
		v.ci = ci;
		v.in_set = 1'b1;
		bound = 128'(radius_model) << (2 * FRAC - RADIUS_FRAC);
		while (!done) begin
			ar = 128'(zr < 0 ? -zr : zr);
			ai = 128'(zi < 0 ? -zi : zi);
			sr = ar * ar;
			si = ai * ai;
			// escape test runs before every step and once after the last
			if (sr + si > bound) begin
				v.in_set = 1'b0;
				done = 1'b1;
			end else if (n >= int'(cap_model)) begin
				done = 1'b1;
			end else begin
				qr = scale_product(sr);
				qi = scale_product(si);
				qx = scale_product(ar * ai);
				if ((zr < 0) != (zi < 0)) qx = -qx;
				nr = qr - qi + longint'(cr);
				ni = 2 * qx + longint'(ci);
				zr = clamp_component(nr);
				zi = clamp_component(ni);
				n++;
			end
		end
		v.iterations = n[ITER_W-1:0];
		return v;
	endfunction

	task automatic send_point(input logic [C_W-1:0] cr, input logic [C_W-1:0] ci);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		c_real <= cr;
		c_imag <= ci;
		pending_verdicts.push_back(escape_time(cr, ci));
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and hold off until every verdict is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAX_ITER)
			cap_model = data[ITER_W-1:0];
		else
			radius_model = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				failures++;
				$display("%0t: unexpected result in_set=%0d iterations=%0d",
					$time, in_set, iterations);
			end else begin
				head = pending_verdicts.pop_front();
				if (in_set !== head.in_set) begin
					failures++;
					$display("%0t: c=(%h,%h) in_set expected %0d actual %0d",
						$time, head.cr, head.ci, head.in_set, in_set);
				end
				if (iterations !== head.iterations) begin
					failures++;
					$display("%0t: c=(%h,%h) iterations expected %0d actual %0d",
						$time, head.cr, head.ci, head.iterations, iterations);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// reset registers: cap 1000, radius 2
	task automatic test_directed();
		send_point(32'h0000_0000, 32'h0000_0000);	// origin, bounded
		send_point(32'hE000_0000, 32'h0000_0000);	// -2.0 sits on the radius forever
		send_point(32'h2000_0000, 32'h0000_0000);	// 2.0 hits the radius then escapes
		send_point(32'hF000_0000, 32'h0000_0000);	// period-two orbit
		send_point(32'h0400_0000, 32'h0000_0000);	// cusp at 0.25
		send_point(32'h0000_0000, 32'h1000_0000);	// i, preperiodic
		send_point(32'h0800_0000, 32'h0800_0000);
		send_point(32'hF400_0000, 32'h0199_999A);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h0000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h0000_0000);
		send_point(32'hFFFF_FFFF, 32'h0000_0001);
		wait_idle();
	endtask

	task automatic test_cap_limits();
		write_reg(REG_MAX_ITER, 32'd0);	// no step is made at all
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h3000_0000, 32'h0000_0000);
		wait_idle();
		write_reg(REG_MAX_ITER, 32'd1);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h3000_0000, 32'h0000_0000);
		send_point(32'h2000_0000, 32'h0000_0000);
		wait_idle();
		write_reg(REG_MAX_ITER, 32'd4095);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'hE000_0000, 32'h0000_0000);
		send_point(32'hF000_0000, 32'h0000_0000);
		send_point(32'h1000_0000, 32'h1000_0000);
		wait_idle();
		write_reg(REG_MAX_ITER, MAX_ITER_RST);
	endtask

	task automatic test_radius_limits();
		write_reg(REG_MAX_ITER, 32'd40);
		write_reg(REG_ESC_RADIUS, 32'd0);	// any nonzero z escapes
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h0000_0001, 32'h0000_0000);
		send_point(32'h0000_0000, 32'h8000_0000);
		wait_idle();
		write_reg(REG_ESC_RADIUS, 32'd1);
		send_point(32'h0000_0001, 32'h0000_0001);
		send_point(32'h0000_4000, 32'h0000_0000);
		send_point(32'hFFFF_C000, 32'h0000_0000);
		wait_idle();
		// widest radius; large points run into the component clamp
		write_reg(REG_ESC_RADIUS, 32'hFFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h1000_0000, 32'h1000_0000);
		wait_idle();
		write_reg(REG_ESC_RADIUS, RADIUS_RST);
		write_reg(REG_MAX_ITER, MAX_ITER_RST);
	endtask

	task automatic test_random(input int count, input int send_pct, input int sink_pct);
		logic [C_W-1:0] cr, ci;
		logic [CFG_DATA_W-1:0] cap, radius;
		send_idle_pct = send_pct;
		sink_stall_pct = sink_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0) begin
				wait_idle();
				// mostly short caps so the run stays fast
				cap = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 1000)
					: $urandom_range(1, 120);
				case ($urandom_range(0, 3))
					0: radius = RADIUS_RST;
					1: radius = $urandom_range(32'h0100_0000, 32'h0800_0000);
					2: radius = $urandom;
					default: radius = $urandom_range(0, 32'h0400_0000);
				endcase
				if ($urandom_range(0, 1)) begin
					write_reg(REG_MAX_ITER, cap);
					write_reg(REG_ESC_RADIUS, radius);
				end else begin
					write_reg(REG_ESC_RADIUS, radius);
					write_reg(REG_MAX_ITER, cap);
				end
			end else if ($urandom_range(0, 49) == 0) begin
				wait_idle();
			end
			case ($urandom_range(0, 3))
				0: begin
					cr = $urandom;
					ci = $urandom;
				end
				1: begin	// within +-2.0
					cr = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
					ci = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
				end
				2: begin	// box around the set
					cr = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
					ci = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
				end
				default: begin
					cr = $urandom;
					ci = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
					if ($urandom_range(0, 1)) {cr, ci} = {ci, cr};
				end
			endcase
			send_point(cr, ci);
		end
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_cap_limits();
		test_radius_limits();
		test_random(200, 10, 46);
		test_random(200, 46, 10);
		test_random(200, 0, 0);
		wait_idle();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(20 * 10_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
